/* design/snd_pkg.sv */
// Shared constants, types and helpers of the synced node device table.
`default_nettype none
package snd_pkg;

    localparam int NODE_SLOTS   = 8;
    localparam int DEV_PER_NODE = 64;
    localparam int NODE_W       = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;
    localparam int NCNT_W       = $clog2(NODE_SLOTS + 1);
    localparam int DEV_W        = (DEV_PER_NODE > 1) ? $clog2(DEV_PER_NODE) : 1;
    localparam int DCNT_W       = $clog2(DEV_PER_NODE + 1);
    localparam int DEV_DEPTH    = NODE_SLOTS * DEV_PER_NODE;
    localparam int ADDR_W       = (DEV_DEPTH > 1) ? $clog2(DEV_DEPTH) : 1;
    localparam int FIFO_DEPTH   = 2;
    localparam int QPTR_W       = $clog2(FIFO_DEPTH);
    localparam int QCNT_W       = $clog2(FIFO_DEPTH + 1);
    localparam logic [31:0] STALE_RESET = 32'd60000;

    typedef enum logic [1:0] {
        OP_REPORT = 2'd0,
        OP_ACK    = 2'd1,
        OP_SWEEP  = 2'd2,
        OP_LOOKUP = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_UPDATED    = 3'd0,
        ST_CREATED    = 3'd1,
        ST_NODE_FULL  = 3'd2,
        ST_DEV_FULL   = 3'd3,
        ST_NOT_FOUND  = 3'd4,
        ST_SWEEP_DONE = 3'd5
    } status_t;

    typedef struct packed {
        logic [47:0] mac;
        logic [7:0]  rssi;
        logic [7:0]  chan;
        logic [31:0] pkts;
        logic        rnd;
        logic [31:0] stamp;
        logic [31:0] win;
    } dev_rec_t;

    typedef struct packed {
        op_t         op;
        logic [47:0] smac;
        logic [47:0] tmac;
        logic [31:0] now;
        logic [7:0]  rssi;
        logic [7:0]  chan;
        logic [31:0] pkts;
        logic        rnd;
        logic [31:0] win;
        logic [31:0] t2;
        logic [30:0] rtt;
        logic [31:0] off;
    } work_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] corr;
        logic [31:0] off;
        logic [30:0] rtt;
        logic [9:0]  evict;
        logic [7:0]  rssi;
        logic [7:0]  chan;
        logic [31:0] pkts;
        logic        rnd;
        logic [31:0] win;
        logic        synced;
        logic [31:0] rep;
    } res_t;

    function automatic logic [ADDR_W-1:0] dev_addr(input logic [NODE_W-1:0] n,
                                                   input logic [DEV_W-1:0] i);
        return ADDR_W'(ADDR_W'(n) * ADDR_W'(DEV_PER_NODE) + ADDR_W'(i));
    endfunction

endpackage
`default_nettype wire

/* design/snd_ram.sv */
// Generic single write port RAM with a registered read port.
`default_nettype none
module snd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                             clk,
    input  wire logic                             we,
    input  wire logic [$clog2(DEPTH)-1:0]         waddr,
    input  wire logic [WIDTH-1:0]                 wdata,
    input  wire logic [$clog2(DEPTH)-1:0]         raddr,
    output logic      [WIDTH-1:0]                 rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* design/snd_queue.sv */
// Short item queue between the front and back parts.
`default_nettype none
module snd_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr_en,
    input  wire snd_pkg::work_t wr_data,
    output logic                full,
    input  wire logic           rd_en,
    output snd_pkg::work_t      rd_data,
    output logic                empty
);
    import snd_pkg::*;

    work_t               slot_reg [FIFO_DEPTH];
    logic [QPTR_W-1:0]   wptr_reg;
    logic [QPTR_W-1:0]   rptr_reg;
    logic [QCNT_W-1:0]   cnt_reg;

    assign full    = (cnt_reg == QCNT_W'(FIFO_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign rd_data = slot_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (wr_en && !full)
            begin
                slot_reg[wptr_reg] <= wr_data;
                wptr_reg <= (wptr_reg == QPTR_W'(FIFO_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (rd_en && !empty)
            begin
                rptr_reg <= (rptr_reg == QPTR_W'(FIFO_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + QCNT_W'(wr_en && !full) - QCNT_W'(rd_en && !empty);
        end
    end
endmodule
`default_nettype wire

/* design/snd_front.sv */
// Front part: accepts items and works out round trip and offset of acknowledgements.
`default_nettype none
module snd_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [1:0]         operation,
    input  wire logic [47:0]        node_mac,
    input  wire logic [47:0]        dev_mac,
    input  wire logic [31:0]        now_ms,
    input  wire logic signed [7:0]  rssi_dbm,
    input  wire logic [7:0]         strong_channel,
    input  wire logic [31:0]        packet_total,
    input  wire logic               mac_random,
    input  wire logic [31:0]        window_num,
    input  wire logic [31:0]        node_time_ms,
    input  wire logic [31:0]        coord_send_ms,
    input  wire logic [31:0]        node_reply_ms,
    output logic                    q_push,
    output snd_pkg::work_t          q_item,
    input  wire logic               q_full
);
    import snd_pkg::*;

    typedef enum logic [1:0] {F_IDLE, F_CALC, F_PUSH} fstate_t;

    fstate_t            state_reg;
    work_t              item_reg;
    logic [31:0]        a_reg;
    logic [31:0]        b_reg;
    logic [31:0]        dt_reg;

    logic signed [32:0] rtt_wide;
    logic [30:0]        rtt_clamp;
    logic signed [33:0] off_wide;
    logic [31:0]        off_clamp;

    assign full   = (state_reg != F_IDLE);
    assign q_push = (state_reg == F_PUSH);
    assign q_item = item_reg;

    always_comb
    begin
        rtt_wide = $signed({a_reg[31], a_reg}) - $signed({b_reg[31], b_reg});
        if (rtt_wide[32])
            rtt_clamp = '0;
        else if (rtt_wide[31])
            rtt_clamp = 31'h7FFF_FFFF;
        else
            rtt_clamp = rtt_wide[30:0];
        off_wide = $signed({{2{dt_reg[31]}}, dt_reg}) - $signed({4'b0000, rtt_clamp[30:1]});
        // Below the signed 32-bit range the offset saturates.
        if (off_wide[33] && (off_wide[32:31] != 2'b11))
            off_clamp = 32'h8000_0000;
        else
            off_clamp = off_wide[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            unique case (state_reg)
                F_IDLE:
                begin
                    if (push)
                    begin
                        item_reg.op   <= op_t'(operation);
                        item_reg.smac <= node_mac;
                        item_reg.tmac <= dev_mac;
                        item_reg.now  <= now_ms;
                        item_reg.rssi <= rssi_dbm;
                        item_reg.chan <= strong_channel;
                        item_reg.pkts <= packet_total;
                        item_reg.rnd  <= mac_random;
                        item_reg.win  <= window_num;
                        item_reg.t2   <= node_time_ms;
                        a_reg         <= now_ms - coord_send_ms;
                        b_reg         <= node_reply_ms - node_time_ms;
                        dt_reg        <= node_time_ms - coord_send_ms;
                        state_reg     <= F_CALC;
                    end
                end
                F_CALC:
                begin
                    item_reg.rtt <= rtt_clamp;
                    item_reg.off <= off_clamp;
                    state_reg    <= F_PUSH;
                end
                F_PUSH:
                begin
                    if (!q_full)
                        state_reg <= F_IDLE;
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

/* design/snd_back.sv */
// Back part: node table, device store walks, sweeps and the result register.
`default_nettype none
module snd_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_empty,
    input  wire snd_pkg::work_t q_item,
    output logic                q_pop,
    input  wire logic           cfg_valid,
    output logic                cfg_ready,
    input  wire logic [31:0]    cfg_data,
    output logic                res_valid,
    output snd_pkg::res_t       res,
    input  wire logic           pop
);
    import snd_pkg::*;

    typedef enum logic [3:0] {
        B_IDLE, B_NSCAN, B_NODE, B_DRD, B_DCMP,
        B_SW_NODE, B_SW_RD, B_SW_CHK, B_SW_MV
    } bstate_t;

    bstate_t             state_reg;
    work_t               cur_reg;
    res_t                res_reg;
    logic                res_valid_reg;
    logic [31:0]         stale_reg;
    logic [NCNT_W-1:0]   node_cnt_reg;
    logic [47:0]         node_mac_reg [NODE_SLOTS];
    logic [DCNT_W-1:0]   dcnt_reg [NODE_SLOTS];
    logic [31:0]         rep_reg [NODE_SLOTS];
    logic [31:0]         off_reg [NODE_SLOTS];
    logic                sync_reg [NODE_SLOTS];
    logic [NCNT_W-1:0]   ni_reg;
    logic [NODE_W-1:0]   n_reg;
    logic                made_reg;
    logic [31:0]         stamp_reg;
    logic [DCNT_W-1:0]   di_reg;
    logic [NCNT_W-1:0]   k_reg;
    logic [DCNT_W-1:0]   i_reg;
    logic [9:0]          ev_reg;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [ADDR_W-1:0]   ram_raddr;
    dev_rec_t            ram_wdata;
    logic [$bits(dev_rec_t)-1:0] ram_rdata;

    dev_rec_t            rec_q;
    dev_rec_t            new_rec;
    logic [DCNT_W-1:0]   cnt_n;
    logic [DCNT_W-1:0]   cnt_k;
    logic [DCNT_W-1:0]   last_k;
    logic [NODE_W-1:0]   k_idx;
    logic                dev_hit;
    logic                stale;

    snd_ram #(
        .WIDTH($bits(dev_rec_t)),
        .DEPTH(DEV_DEPTH)
    ) u_dev_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign cfg_ready = 1'b1;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign q_pop     = (state_reg == B_IDLE) && !q_empty && !res_valid_reg;

    assign rec_q   = dev_rec_t'(ram_rdata);
    assign k_idx   = k_reg[NODE_W-1:0];
    assign cnt_n   = dcnt_reg[n_reg];
    assign cnt_k   = dcnt_reg[k_idx];
    assign last_k  = cnt_k - DCNT_W'(1);
    assign dev_hit = (rec_q.mac == cur_reg.tmac);
    assign stale   = ((cur_reg.now - rec_q.stamp) > stale_reg);

    always_comb
    begin
        new_rec.mac   = cur_reg.tmac;
        new_rec.rssi  = cur_reg.rssi;
        new_rec.chan  = cur_reg.chan;
        new_rec.pkts  = cur_reg.pkts;
        new_rec.rnd   = cur_reg.rnd;
        new_rec.stamp = stamp_reg;
        new_rec.win   = cur_reg.win;
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_raddr = '0;
        ram_wdata = new_rec;
        case (state_reg)
            B_DRD:
            begin
                ram_raddr = dev_addr(n_reg, di_reg[DEV_W-1:0]);
                if ((di_reg == cnt_n) && (cur_reg.op == OP_REPORT) &&
                    (cnt_n != DCNT_W'(DEV_PER_NODE)))
                begin
                    ram_we    = 1'b1;
                    ram_waddr = dev_addr(n_reg, cnt_n[DEV_W-1:0]);
                end
            end
            B_DCMP:
            begin
                if (dev_hit && (cur_reg.op == OP_REPORT))
                begin
                    ram_we    = 1'b1;
                    ram_waddr = dev_addr(n_reg, di_reg[DEV_W-1:0]);
                end
            end
            B_SW_RD:  ram_raddr = dev_addr(k_idx, i_reg[DEV_W-1:0]);
            B_SW_CHK: ram_raddr = dev_addr(k_idx, last_k[DEV_W-1:0]);
            B_SW_MV:
            begin
                // The last entry read in the check cycle fills the evicted place.
                ram_we    = 1'b1;
                ram_waddr = dev_addr(k_idx, i_reg[DEV_W-1:0]);
                ram_wdata = rec_q;
            end
            default: ram_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        res_t r;
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            res_valid_reg <= 1'b0;
            stale_reg     <= STALE_RESET;
            node_cnt_reg  <= '0;
        end
        else
        begin
            r = '0;
            r.off    = off_reg[n_reg];
            r.synced = sync_reg[n_reg];
            r.rep    = rep_reg[n_reg];
            if (cfg_valid)
                stale_reg <= cfg_data;
            if (pop && res_valid_reg)
                res_valid_reg <= 1'b0;

            unique case (state_reg)
                B_IDLE:
                begin
                    if (q_pop)
                    begin
                        cur_reg   <= q_item;
                        ni_reg    <= '0;
                        k_reg     <= '0;
                        ev_reg    <= '0;
                        state_reg <= (q_item.op == OP_SWEEP) ? B_SW_NODE : B_NSCAN;
                    end
                end
                B_NSCAN:
                begin
                    if (ni_reg != node_cnt_reg)
                    begin
                        if (node_mac_reg[ni_reg[NODE_W-1:0]] == cur_reg.smac)
                        begin
                            n_reg     <= ni_reg[NODE_W-1:0];
                            made_reg  <= 1'b0;
                            state_reg <= B_NODE;
                        end
                        else
                            ni_reg <= ni_reg + 1'b1;
                    end
                    else if (cur_reg.op == OP_LOOKUP)
                    begin
                        r = '0;
                        r.status = ST_NOT_FOUND;
                        res_reg       <= r;
                        res_valid_reg <= 1'b1;
                        state_reg     <= B_IDLE;
                    end
                    else if (node_cnt_reg == NCNT_W'(NODE_SLOTS))
                    begin
                        r = '0;
                        r.status = ST_NODE_FULL;
                        if (cur_reg.op == OP_ACK)
                        begin
                            r.rtt = cur_reg.rtt;
                            r.off = cur_reg.off;
                        end
                        res_reg       <= r;
                        res_valid_reg <= 1'b1;
                        state_reg     <= B_IDLE;
                    end
                    else
                    begin
                        node_mac_reg[node_cnt_reg[NODE_W-1:0]] <= cur_reg.smac;
                        dcnt_reg[node_cnt_reg[NODE_W-1:0]]     <= '0;
                        rep_reg[node_cnt_reg[NODE_W-1:0]]      <= '0;
                        off_reg[node_cnt_reg[NODE_W-1:0]]      <= '0;
                        sync_reg[node_cnt_reg[NODE_W-1:0]]     <= 1'b0;
                        n_reg        <= node_cnt_reg[NODE_W-1:0];
                        node_cnt_reg <= node_cnt_reg + 1'b1;
                        made_reg     <= 1'b1;
                        state_reg    <= B_NODE;
                    end
                end
                B_NODE:
                begin
                    di_reg <= '0;
                    case (cur_reg.op)
                        OP_ACK:
                        begin
                            off_reg[n_reg]  <= cur_reg.off;
                            sync_reg[n_reg] <= 1'b1;
                            r.status = made_reg ? ST_CREATED : ST_UPDATED;
                            r.off    = cur_reg.off;
                            r.rtt    = cur_reg.rtt;
                            r.synced = 1'b1;
                            res_reg       <= r;
                            res_valid_reg <= 1'b1;
                            state_reg     <= B_IDLE;
                        end
                        OP_REPORT:
                        begin
                            rep_reg[n_reg] <= rep_reg[n_reg] + 32'd1;
                            stamp_reg <= sync_reg[n_reg] ? cur_reg.t2 - off_reg[n_reg]
                                                         : cur_reg.now;
                            state_reg <= B_DRD;
                        end
                        default: state_reg <= B_DRD;
                    endcase
                end
                B_DRD:
                begin
                    if (di_reg == cnt_n)
                    begin
                        if (cur_reg.op != OP_REPORT)
                            r.status = ST_NOT_FOUND;
                        else if (cnt_n == DCNT_W'(DEV_PER_NODE))
                            r.status = ST_DEV_FULL;
                        else
                        begin
                            dcnt_reg[n_reg] <= cnt_n + 1'b1;
                            r.status = ST_CREATED;
                            r.corr   = new_rec.stamp;
                            r.rssi   = new_rec.rssi;
                            r.chan   = new_rec.chan;
                            r.pkts   = new_rec.pkts;
                            r.rnd    = new_rec.rnd;
                            r.win    = new_rec.win;
                        end
                        res_reg       <= r;
                        res_valid_reg <= 1'b1;
                        state_reg     <= B_IDLE;
                    end
                    else
                        state_reg <= B_DCMP;
                end
                B_DCMP:
                begin
                    if (dev_hit)
                    begin
                        r.status = ST_UPDATED;
                        if (cur_reg.op == OP_REPORT)
                        begin
                            r.corr = new_rec.stamp;
                            r.rssi = new_rec.rssi;
                            r.chan = new_rec.chan;
                            r.pkts = new_rec.pkts;
                            r.rnd  = new_rec.rnd;
                            r.win  = new_rec.win;
                        end
                        else
                        begin
                            r.corr = rec_q.stamp;
                            r.rssi = rec_q.rssi;
                            r.chan = rec_q.chan;
                            r.pkts = rec_q.pkts;
                            r.rnd  = rec_q.rnd;
                            r.win  = rec_q.win;
                        end
                        res_reg       <= r;
                        res_valid_reg <= 1'b1;
                        state_reg     <= B_IDLE;
                    end
                    else
                    begin
                        di_reg    <= di_reg + 1'b1;
                        state_reg <= B_DRD;
                    end
                end
                B_SW_NODE:
                begin
                    if (k_reg == node_cnt_reg)
                    begin
                        r = '0;
                        r.status = ST_SWEEP_DONE;
                        r.evict  = ev_reg;
                        res_reg       <= r;
                        res_valid_reg <= 1'b1;
                        state_reg     <= B_IDLE;
                    end
                    else
                    begin
                        i_reg     <= '0;
                        state_reg <= B_SW_RD;
                    end
                end
                B_SW_RD:
                begin
                    if (i_reg == cnt_k)
                    begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= B_SW_NODE;
                    end
                    else
                        state_reg <= B_SW_CHK;
                end
                B_SW_CHK:
                begin
                    if (stale)
                    begin
                        dcnt_reg[k_idx] <= last_k;
                        ev_reg          <= ev_reg + 10'd1;
                        state_reg       <= B_SW_MV;
                    end
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= B_SW_RD;
                    end
                end
                B_SW_MV: state_reg <= B_SW_RD;
                default: state_reg <= B_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

/* design/synced_node_device_table_top.sv */
// Top level of the synced node device table: front, item queue and back.
// Front: an item passes the calc and push states into the queue; no new item until it is in.
// Back, after its pop: known nodes are compared one a cycle; for a report or lookup
// each of the D devices is then read in B_DRD and compared in B_DCMP.
// Sweep: B_SW_NODE per node, B_SW_RD and B_SW_CHK per entry, B_SW_MV per evicted entry.
// Reset empties the node table and sets the stale limit to 60000; no clearing pass.
`default_nettype none
module synced_node_device_table_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [1:0]         operation,
    input  wire logic [47:0]        node_mac,
    input  wire logic [47:0]        dev_mac,
    input  wire logic [31:0]        now_ms,
    input  wire logic signed [7:0]  rssi_dbm,
    input  wire logic [7:0]         strong_channel,
    input  wire logic [31:0]        packet_total,
    input  wire logic               mac_random,
    input  wire logic [31:0]        window_num,
    input  wire logic [31:0]        node_time_ms,
    input  wire logic [31:0]        coord_send_ms,
    input  wire logic [31:0]        node_reply_ms,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [31:0]        cfg_data,
    output logic                    empty,
    input  wire logic               pop,
    output logic [2:0]              status,
    output logic [31:0]             corrected_time_ms,
    output logic signed [31:0]      offset_ms,
    output logic [30:0]             round_trip_ms,
    output logic [9:0]              evicted_count,
    output logic signed [7:0]       stored_rssi,
    output logic [7:0]              stored_channel,
    output logic [31:0]             stored_packets,
    output logic                    stored_random,
    output logic [31:0]             stored_window,
    output logic                    node_synced,
    output logic [31:0]             report_total
);
    import snd_pkg::*;

    logic   q_push;
    logic   q_full;
    logic   q_pop;
    logic   q_empty;
    work_t  q_wr_item;
    work_t  q_rd_item;
    logic   res_valid;
    res_t   res;

    snd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .operation     (operation),
        .node_mac      (node_mac),
        .dev_mac       (dev_mac),
        .now_ms        (now_ms),
        .rssi_dbm      (rssi_dbm),
        .strong_channel(strong_channel),
        .packet_total  (packet_total),
        .mac_random    (mac_random),
        .window_num    (window_num),
        .node_time_ms  (node_time_ms),
        .coord_send_ms (coord_send_ms),
        .node_reply_ms (node_reply_ms),
        .q_push        (q_push),
        .q_item        (q_wr_item),
        .q_full        (q_full)
    );

    snd_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (q_push),
        .wr_data(q_wr_item),
        .full   (q_full),
        .rd_en  (q_pop),
        .rd_data(q_rd_item),
        .empty  (q_empty)
    );

    snd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_item   (q_rd_item),
        .q_pop    (q_pop),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .res_valid(res_valid),
        .res      (res),
        .pop      (pop)
    );

    assign empty             = !res_valid;
    assign status            = 3'(res.status);
    assign corrected_time_ms = res.corr;
    assign offset_ms         = $signed(res.off);
    assign round_trip_ms     = res.rtt;
    assign evicted_count     = res.evict;
    assign stored_rssi       = $signed(res.rssi);
    assign stored_channel    = res.chan;
    assign stored_packets    = res.pkts;
    assign stored_random     = res.rnd;
    assign stored_window     = res.win;
    assign node_synced       = res.synced;
    assign report_total      = res.rep;
endmodule
`default_nettype wire
